/* rtl/u8d_pkg.sv */
// Package for the UTF-8 stream decoder: status codes, widths and the
// per-word step result type. No dependencies.
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int REM_W  = 2;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [CP_W-1:0]  partial;
    } t_dec_state;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        t_status         status;
        t_dec_state      next;
    } t_step;

endpackage

/* rtl/u8d_if.sv */
// Valid/ready channel interfaces for the byte input and the code point output.
// Depends on u8d_pkg.
interface u8d_in_if
    import u8d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface u8d_out_if
    import u8d_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    logic [1:0]      status;

    modport source (output valid, output code_point, output status, input ready);
    modport sink   (input valid, input code_point, input status, output ready);
endinterface

/* rtl/u8d_step.sv */
// Combinational decode of one byte against the current sequence state.
// Depends on u8d_pkg.
module u8d_step
    import u8d_pkg::*;
(
    input  t_dec_state        i_state,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_eob,
    output t_step             o_step
);

    logic [CP_W-1:0] w_shifted;

    assign w_shifted = {i_state.partial[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        o_step              = '0;
        o_step.status       = ST_OK;
        o_step.next         = i_state;
        if (i_state.rem == '0) begin
            if (!i_byte[7]) begin
                o_step.emit       = 1'b1;
                o_step.code_point = CP_W'(i_byte);
            end else if (i_byte[7:6] == 2'b10 || i_byte[7:3] == 5'b11111) begin
                o_step.emit   = 1'b1;
                o_step.status = ST_BAD_LEAD;
            end else if (i_eob) begin
                o_step.emit   = 1'b1;
                o_step.status = ST_TRUNC;
            end else if (!i_byte[5]) begin
                o_step.next.rem     = 2'd1;
                o_step.next.partial = CP_W'(i_byte[4:0]);
            end else if (!i_byte[4]) begin
                o_step.next.rem     = 2'd2;
                o_step.next.partial = CP_W'(i_byte[3:0]);
            end else begin
                o_step.next.rem     = 2'd3;
                o_step.next.partial = CP_W'(i_byte[2:0]);
            end
        end else if (i_byte[7:6] != 2'b10) begin
            o_step.emit   = 1'b1;
            o_step.status = ST_BAD_CONT;
            o_step.next   = '0;
        end else if (i_state.rem == 2'd1) begin
            o_step.emit       = 1'b1;
            o_step.code_point = w_shifted;
            o_step.next       = '0;
        end else if (i_eob) begin
            o_step.emit   = 1'b1;
            o_step.status = ST_TRUNC;
            o_step.next   = '0;
        end else begin
            o_step.next.rem     = i_state.rem - 2'd1;
            o_step.next.partial = w_shifted;
        end
    end

endmodule

/* rtl/utf8_stream_decoder.sv */
// UTF-8 stream decoder top level: input register, step logic, result register.
// Depends on u8d_pkg, u8d_if and u8d_step.
//
// Usage:
//   i_in takes one raw byte per word with an end-of-buffer flag. o_out gives
//   one code point with a status per result word: ok, bad lead byte, bad
//   continuation or truncated sequence; code_point is zero on any error.
//   Valid lead and continuation bytes that do not complete or end a sequence give no result word.
//   The byte that completes a result word goes through the input register,
//   then the step logic, and the result word lands in the result register.
//   Throughput: one byte per cycle while o_out does not stall a pending result,
//   set by the combinational step logic that updates the sequence state.
//   A new byte is accepted while a result word waits, as long as the held byte
//   either makes no result or the result register frees in the same cycle.
//   When o_out stalls with a result pending, the next byte that makes a result
//   waits in the input register and i_in.ready drops behind it.
//   Reset clears both valid flags and returns the decoder to idle with no
//   partial code point.
module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    u8d_in_if.sink  i_in,
    u8d_out_if.source o_out
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_eob;
    t_dec_state        r_state;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    t_status           r_out_status;
    t_step             w_step;
    logic              w_adv;

    u8d_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eob   (r_in_eob),
        .o_step  (w_step)
    );

    assign w_adv = r_in_valid && (!w_step.emit || !r_out_valid || o_out.ready);

    assign i_in.ready       = !r_in_valid || w_adv;
    assign o_out.valid      = r_out_valid;
    assign o_out.code_point = r_out_cp;
    assign o_out.status     = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_in.in_byte;
                r_in_eob   <= i_in.end_of_buffer;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_state <= w_step.next;
            end
            if (w_adv && w_step.emit) begin
                r_out_valid  <= 1'b1;
                r_out_cp     <= w_step.code_point;
                r_out_status <= w_step.status;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_err_zero_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_cp == '0)
        else $error("error result carries a nonzero code point");

    a_idle_no_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.rem == '0 |-> r_state.partial == '0)
        else $error("partial code point left over in idle");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_step.emit |=> r_out_valid)
        else $error("result word lost on advance");

    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled byte dropped from input register");

endmodule
